### rtl/fbpc_pkg.sv
// shared types and constants of the frustum box and point cull unit
package fbpc_pkg;

    localparam int NUM_PLANES = 6;
    localparam int BOX_PLANES = 5;
    localparam int CORNERS    = 8;
    localparam int TERM_W     = 16;
    localparam int PLANE_W    = 64;
    localparam int CFG_IDX_W  = 3;
    localparam int D_SHIFT    = 14;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PLANE_RIGHT  = 3'd0,
        REG_PLANE_LEFT   = 3'd1,
        REG_PLANE_BOTTOM = 3'd2,
        REG_PLANE_TOP    = 3'd3,
        REG_PLANE_FRONT  = 3'd4,
        REG_PLANE_BACK   = 3'd5
    } reg_idx_t;

    typedef enum logic [1:0] {
        VIS_INVISIBLE = 2'd0,
        VIS_PARTIAL   = 2'd1,
        VIS_COMPLETE  = 2'd2
    } vis_t;

    typedef enum logic {
        REQ_POINT = 1'b0,
        REQ_BOX   = 1'b1
    } req_t;

    // packed plane register, d in the top slot and a in the bottom
    typedef struct packed {
        logic signed [TERM_W-1:0] d;
        logic signed [TERM_W-1:0] c;
        logic signed [TERM_W-1:0] b;
        logic signed [TERM_W-1:0] a;
    } plane_t;

    typedef logic [CORNERS-1:0] front_t;

endpackage

### rtl/fbpc_plane_regs.sv
// plane configuration registers with write port
module fbpc_plane_regs
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_valid,
    input  logic [fbpc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [fbpc_pkg::PLANE_W-1:0]    cfg_data,
    output fbpc_pkg::plane_t                planes [fbpc_pkg::NUM_PLANES]
);

    fbpc_pkg::plane_t plane_reg [fbpc_pkg::NUM_PLANES];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < fbpc_pkg::NUM_PLANES; i++)
            begin
                plane_reg[i] <= '0;
            end
        end
        else if (cfg_valid)
        begin
            // indexes past the back plane are dropped
            for (int i = 0; i < fbpc_pkg::NUM_PLANES; i++)
            begin
                if (cfg_index == fbpc_pkg::CFG_IDX_W'(i))
                begin
                    plane_reg[i] <= fbpc_pkg::plane_t'(cfg_data);
                end
            end
        end
    end

    assign planes = plane_reg;

endmodule

### rtl/fbpc_plane_eval.sv
// three-stage corner distance sign test against one plane
module fbpc_plane_eval
#(
    parameter int COORD_WIDTH = 16
)
(
    input  logic                           clk,
    input  logic                           adv,
    input  fbpc_pkg::plane_t               plane,
    input  logic signed [COORD_WIDTH-1:0]  lo_x,
    input  logic signed [COORD_WIDTH-1:0]  lo_y,
    input  logic signed [COORD_WIDTH-1:0]  lo_z,
    input  logic signed [COORD_WIDTH-1:0]  hi_x,
    input  logic signed [COORD_WIDTH-1:0]  hi_y,
    input  logic signed [COORD_WIDTH-1:0]  hi_z,
    output fbpc_pkg::front_t               front
);

    localparam int PW   = fbpc_pkg::TERM_W + COORD_WIDTH;
    localparam int DW   = fbpc_pkg::TERM_W + fbpc_pkg::D_SHIFT;
    localparam int SW   = ((PW > DW) ? PW : DW) + 2;

    // stage 1: products
    logic signed [PW-1:0]            px_lo_reg, px_hi_reg;
    logic signed [PW-1:0]            py_lo_reg, py_hi_reg;
    logic signed [PW-1:0]            pz_lo_reg, pz_hi_reg;
    logic signed [fbpc_pkg::TERM_W-1:0] d1_reg;

    // stage 2: x/y partial sums with offset, z products carried
    logic signed [SW-1:0]            sxy_reg [4];
    logic signed [SW-1:0]            sxy_next [4];
    logic signed [PW-1:0]            pz2_lo_reg, pz2_hi_reg;

    // stage 3: front bits
    fbpc_pkg::front_t                front_reg, front_next;
    logic signed [SW-1:0]            dterm;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            px_lo_reg <= PW'(plane.a) * PW'(lo_x);
            px_hi_reg <= PW'(plane.a) * PW'(hi_x);
            py_lo_reg <= PW'(plane.b) * PW'(lo_y);
            py_hi_reg <= PW'(plane.b) * PW'(hi_y);
            pz_lo_reg <= PW'(plane.c) * PW'(lo_z);
            pz_hi_reg <= PW'(plane.c) * PW'(hi_z);
            d1_reg    <= plane.d;
        end
    end

    assign dterm = SW'(d1_reg) <<< fbpc_pkg::D_SHIFT;

    always_comb
    begin
        for (int j = 0; j < 4; j++)
        begin
            sxy_next[j] = (j[0] ? SW'(px_hi_reg) : SW'(px_lo_reg))
                        + (j[1] ? SW'(py_hi_reg) : SW'(py_lo_reg))
                        + dterm;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sxy_reg    <= sxy_next;
            pz2_lo_reg <= pz_lo_reg;
            pz2_hi_reg <= pz_hi_reg;
        end
    end

    // corner k: bit 0 picks x, bit 1 picks y, bit 2 picks z
    always_comb
    begin
        for (int k = 0; k < fbpc_pkg::CORNERS; k++)
        begin
            front_next[k] = (sxy_reg[k % 4]
                            + (k[2] ? SW'(pz2_hi_reg) : SW'(pz2_lo_reg))) > SW'(0);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            front_reg <= front_next;
        end
    end

    assign front = front_reg;

endmodule

### rtl/fbpc_classify.sv
// final stage: combines per-plane front bits into a visibility code
module fbpc_classify
(
    input  logic                 clk,
    input  logic                 adv,
    input  fbpc_pkg::req_t       req_type,
    input  fbpc_pkg::front_t     front [fbpc_pkg::NUM_PLANES],
    output fbpc_pkg::vis_t       visibility
);

    fbpc_pkg::vis_t vis_reg, vis_next;
    logic           any_behind;
    logic           all_front;
    logic           point_in;

    always_comb
    begin
        any_behind = 1'b0;
        all_front  = 1'b1;
        point_in   = 1'b1;
        for (int p = 0; p < fbpc_pkg::BOX_PLANES; p++)
        begin
            any_behind = any_behind | ~(|front[p]);
            all_front  = all_front & (&front[p]);
        end
        for (int p = 0; p < fbpc_pkg::NUM_PLANES; p++)
        begin
            point_in = point_in & front[p][0];
        end

        unique case (req_type)
            fbpc_pkg::REQ_POINT:
            begin
                vis_next = point_in ? fbpc_pkg::VIS_COMPLETE : fbpc_pkg::VIS_INVISIBLE;
            end
            fbpc_pkg::REQ_BOX:
            begin
                if (any_behind)
                begin
                    vis_next = fbpc_pkg::VIS_INVISIBLE;
                end
                else if (all_front)
                begin
                    vis_next = fbpc_pkg::VIS_COMPLETE;
                end
                else
                begin
                    vis_next = fbpc_pkg::VIS_PARTIAL;
                end
            end
            default:
            begin
                vis_next = fbpc_pkg::VIS_INVISIBLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            vis_reg <= vis_next;
        end
    end

    assign visibility = vis_reg;

endmodule

### rtl/frustum_box_point_cull_unit.sv
// top level of the frustum box and point cull unit
//
//   channel | handshake            | payload
//   --------+----------------------+------------------------------------------
//   cfg     | cfg_valid/cfg_ready  | cfg_index, cfg_data (one plane register)
//   req     | req_valid/req_ready  | req_type, min_x/y/z, max_x/y/z
//   rsp     | rsp_valid/rsp_ready  | visibility
//
// one item per cycle while the pipeline does not hold
// stages: products, x/y sums, corner sign tests, classification
// the whole pipeline holds when the result register is full and not taken
// reset clears the plane registers and the valid bits; cfg is always ready
module frustum_box_point_cull_unit
#(
    parameter int COORD_WIDTH = 16
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [fbpc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [fbpc_pkg::PLANE_W-1:0]        cfg_data,
    input  logic                                req_valid,
    output logic                                req_ready,
    input  logic                                req_type,
    input  logic signed [COORD_WIDTH-1:0]       min_x,
    input  logic signed [COORD_WIDTH-1:0]       min_y,
    input  logic signed [COORD_WIDTH-1:0]       min_z,
    input  logic signed [COORD_WIDTH-1:0]       max_x,
    input  logic signed [COORD_WIDTH-1:0]       max_y,
    input  logic signed [COORD_WIDTH-1:0]       max_z,
    output logic                                rsp_valid,
    input  logic                                rsp_ready,
    output logic [1:0]                          visibility
);

    fbpc_pkg::plane_t  planes [fbpc_pkg::NUM_PLANES];
    fbpc_pkg::front_t  front  [fbpc_pkg::NUM_PLANES];
    fbpc_pkg::vis_t    vis;
    logic              adv;

    logic v1_reg, v2_reg, v3_reg, v4_reg;
    fbpc_pkg::req_t typ1_reg, typ2_reg, typ3_reg, typ4_reg;

    assign cfg_ready = 1'b1;
    assign adv       = !v4_reg || rsp_ready;
    assign req_ready = adv;
    assign rsp_valid = v4_reg;
    assign visibility = vis;

    fbpc_plane_regs u_regs
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .planes    (planes)
    );

    for (genvar p = 0; p < fbpc_pkg::NUM_PLANES; p++)
    begin : g_plane
        fbpc_plane_eval #(.COORD_WIDTH(COORD_WIDTH)) u_eval
        (
            .clk   (clk),
            .adv   (adv),
            .plane (planes[p]),
            .lo_x  (min_x),
            .lo_y  (min_y),
            .lo_z  (min_z),
            .hi_x  (max_x),
            .hi_y  (max_y),
            .hi_z  (max_z),
            .front (front[p])
        );
    end

    fbpc_classify u_classify
    (
        .clk        (clk),
        .adv        (adv),
        .req_type   (typ3_reg),
        .front      (front),
        .visibility (vis)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= req_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            typ1_reg <= fbpc_pkg::req_t'(req_type);
            typ2_reg <= typ1_reg;
            typ3_reg <= typ2_reg;
            typ4_reg <= typ3_reg;
        end
    end

    // a point never comes out as partial
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && typ4_reg == fbpc_pkg::REQ_POINT |-> vis != fbpc_pkg::VIS_PARTIAL)
        else $error("point item classified as partial");

    // only the three defined codes leave the block
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (vis == fbpc_pkg::VIS_INVISIBLE || vis == fbpc_pkg::VIS_PARTIAL
                       || vis == fbpc_pkg::VIS_COMPLETE))
        else $error("undefined visibility code");

    // a stall freezes every valid bit of the pipeline
    assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> v1_reg == $past(v1_reg) && v2_reg == $past(v2_reg)
                 && v3_reg == $past(v3_reg) && v4_reg == $past(v4_reg))
        else $error("pipeline moved during stall");

    // with no stall an accepted item reaches rsp_valid
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready ##1 adv ##1 adv ##1 adv |=> rsp_valid)
        else $error("accepted item lost in pipeline");

endmodule
